/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue_unit.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH      = 128;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned STATUS_W   = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]        data;
    logic signed [PRIO_WIDTH-1:0] prio;
  } spq_entry_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage
`default_nettype wire

/* sv/spq_cell.sv */
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
  input  wire                      clk_i,
  input  wire spq_pkg::spq_cmd_t   cmd_i,
  input  wire                      occupied_i,
  input  wire                      above_take_i,
  input  wire spq_pkg::spq_entry_t above_entry_i,
  input  wire spq_pkg::spq_entry_t below_entry_i,
  output logic                     take_o,
  output spq_pkg::spq_entry_t      entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // new item belongs here or above: strictly higher priority, or a free slot
  assign take_o = cmd_i.enq && (!occupied_i || (cmd_i.entry.prio > entry_q.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (above_take_i) begin
        entry_d = above_entry_i;
      end else if (take_o) begin
        entry_d = cmd_i.entry;
      end
    end else if (cmd_i.deq) begin
      entry_d = below_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* sv/sorted_priority_queue_unit.sv */
// Sorted priority queue top level: a row of spq_cell slots plus count and output register.
// Depends on spq_pkg and spq_cell.
//
// Holds up to 128 entries sorted by descending signed priority, equal priorities
// leaving in arrival order. On every beat (enqueue or dequeue) all slots compare
// the new priority against their own at once and shift by one toward the tail
// on insert or toward the head on removal. Each beat yields one result beat from
// an output register; a new beat is taken whenever that register is empty or
// being drained in the same cycle, so one beat is taken per cycle while the output
// drains. An enqueue into a full queue is dropped with status 1, a dequeue from
// an empty queue returns zeros with status 2; count is the fill after the beat.
`default_nettype none
module sorted_priority_queue_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               operation_i,
  input  wire signed [spq_pkg::DATA_WIDTH-1:0] data_i,
  input  wire signed [spq_pkg::PRIO_WIDTH-1:0] priority_req_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              item_valid_o,
  output logic signed [spq_pkg::DATA_WIDTH-1:0] out_data_o,
  output logic signed [spq_pkg::PRIO_WIDTH-1:0] out_priority_o,
  output logic [spq_pkg::STATUS_W-1:0]      status_o,
  output logic [spq_pkg::COUNT_W-1:0]       count_o
);
  import spq_pkg::*;

  logic                    in_fire;
  logic                    is_full, is_empty;
  spq_cmd_t                cmd;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [DEPTH-1:0]        take;
  spq_entry_t              entries [DEPTH];

  logic                    out_valid_q, out_valid_d;
  logic                    item_valid_q, item_valid_d;
  logic [DATA_WIDTH-1:0]   out_data_q, out_data_d;
  logic [PRIO_WIDTH-1:0]   out_prio_q, out_prio_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [COUNT_W-1:0]      count_out_q, count_out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CNT_W'(DEPTH));
  assign is_empty   = (count_q == '0);

  always_comb begin
    cmd.enq        = in_fire && (operation_i == OP_ENQ) && !is_full;
    cmd.deq        = in_fire && (operation_i == OP_DEQ) && !is_empty;
    cmd.entry.data = data_i;
    cmd.entry.prio = priority_req_i;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occupied;
    logic       above_take;
    spq_entry_t above_entry;
    spq_entry_t below_entry;

    assign occupied = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign above_take  = 1'b0;
      assign above_entry = entries[i];
    end else begin : g_mid
      assign above_take  = take[i-1];
      assign above_entry = entries[i-1];
    end

    // tail slot just keeps its stale value on dequeue, it falls out of range
    if (i == DEPTH - 1) begin : g_tail
      assign below_entry = entries[i];
    end else begin : g_body
      assign below_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (occupied),
      .above_take_i  (above_take),
      .above_entry_i (above_entry),
      .below_entry_i (below_entry),
      .take_o        (take[i]),
      .entry_o       (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    item_valid_d = item_valid_q;
    out_data_d   = out_data_q;
    out_prio_d   = out_prio_q;
    status_d     = status_q;
    count_out_d  = count_out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d  = 1'b1;
      item_valid_d = cmd.deq;
      out_data_d   = cmd.deq ? entries[0].data : '0;
      out_prio_d   = cmd.deq ? entries[0].prio : '0;
      count_out_d  = COUNT_W'(count_d);
      if (operation_i == OP_ENQ) begin
        status_d = is_full ? STATUS_FULL : STATUS_OK;
      end else begin
        status_d = is_empty ? STATUS_EMPTY : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_valid_q <= item_valid_d;
    out_data_q   <= out_data_d;
    out_prio_q   <= out_prio_d;
    status_q     <= status_d;
    count_out_q  <= count_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign item_valid_o   = item_valid_q;
  assign out_data_o     = out_data_q;
  assign out_priority_o = out_prio_q;
  assign status_o       = status_q;
  assign count_o        = count_out_q;

endmodule
`default_nettype wire
